[hdl/rtsm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtsm_pkg: shared types and limits of the rail and temperature monitor
// Check numbering, limit table, fault kind codes and the struct types that
// travel between the evaluator, the counter bank and the top level.
// ----------------------------------------------------------------------------
package rtsm_pkg;

  // Check numbering
  localparam int CHECK_SLOTS = 32;            // checks that the mask can address
  localparam int NUM_W       = 5;
  localparam logic [NUM_W-1:0] LAST_CHECK  = 5'd21;
  localparam logic [NUM_W-1:0] FIRST_SOFT  = 5'd2;
  localparam logic [NUM_W-1:0] LAST_SOFT   = 5'd4;

  // Datapath widths
  localparam int SMP_W   = 16;
  localparam int CNT_W   = 7;
  localparam int RAILS   = 3;
  localparam int RAIL_W  = 2;
  localparam int KIND_W  = 2;
  localparam int MASK_W  = 32;
  localparam int CFG_IDX_W = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DISABLE_MASK = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_LIMIT = 2'd1;

  localparam logic [MASK_W-1:0] DISABLE_MASK_RST = '0;
  localparam logic [CNT_W-1:0]  REPEAT_LIMIT_RST = 7'd100;

  // Fault kinds
  localparam logic [KIND_W-1:0] KIND_NONE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_HARD = 2'd1;
  localparam logic [KIND_W-1:0] KIND_SOFT = 2'd2;

  // Hard windows of plain rails
  localparam logic signed [SMP_W-1:0] R0_LO = 16'sd1500;
  localparam logic signed [SMP_W-1:0] R0_HI = 16'sd2600;
  localparam logic signed [SMP_W-1:0] R1_LO = 16'sd1700;
  localparam logic signed [SMP_W-1:0] R1_HI = 16'sd1900;
  localparam logic signed [SMP_W-1:0] R5_LO = 16'sd28000;
  localparam logic signed [SMP_W-1:0] R5_HI = 16'sd29500;

  // Rails with a soft lower bound
  localparam logic signed [SMP_W-1:0] R2_LO   = 16'sd3100;
  localparam logic signed [SMP_W-1:0] R2_SOFT = 16'sd3150;
  localparam logic signed [SMP_W-1:0] R2_HI   = 16'sd4000;
  localparam logic signed [SMP_W-1:0] R3_LO   = 16'sd4250;
  localparam logic signed [SMP_W-1:0] R3_SOFT = 16'sd4300;
  localparam logic signed [SMP_W-1:0] R3_HI   = 16'sd5750;
  localparam logic signed [SMP_W-1:0] R4_LO   = -16'sd7600;
  localparam logic signed [SMP_W-1:0] R4_SOFT = -16'sd7500;
  localparam logic signed [SMP_W-1:0] R4_HI   = -16'sd5350;

  // Over-temperature limits
  localparam logic signed [SMP_W-1:0] TEMP_LOW  = 16'sd60;
  localparam logic signed [SMP_W-1:0] TEMP_MID  = 16'sd70;
  localparam logic signed [SMP_W-1:0] TEMP_HIGH = 16'sd90;

  typedef logic [RAILS-1:0][CNT_W-1:0] cnt_vec_t;

  // Counter bank update request
  typedef struct packed {
    logic              upd;
    logic              clr_all;
    logic [RAIL_W-1:0] rail;
    logic [CNT_W-1:0]  val;
  } cnt_ctl_t;

  // One result beat
  typedef struct packed {
    logic              fault;
    logic [KIND_W-1:0] kind;
    logic [NUM_W-1:0]  next;
    logic [CNT_W-1:0]  low;
  } res_t;

endpackage

[hdl/rtsm_eval.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtsm_eval: limit check of one sample
// Compares the registered sample with its check's limits, decides the fault
// kind and the next check, and requests the soft-low counter update or clear.
// ----------------------------------------------------------------------------
module rtsm_eval (
  input  logic [rtsm_pkg::NUM_W-1:0]        num,
  input  logic signed [rtsm_pkg::SMP_W-1:0] smp,
  input  logic [rtsm_pkg::MASK_W-1:0]       disable_mask,
  input  logic [rtsm_pkg::CNT_W-1:0]        repeat_limit,
  input  rtsm_pkg::cnt_vec_t                cnt,
  output rtsm_pkg::res_t                    res,
  output rtsm_pkg::cnt_ctl_t                ctl
);
  import rtsm_pkg::*;

  always_comb begin
    logic              in_range;
    logic              is_rail;
    logic              disabled;
    logic [RAIL_W-1:0] rail;
    logic [CNT_W-1:0]  cur;
    logic [CNT_W-1:0]  nval;
    logic              upd;
    logic [KIND_W-1:0] kind;
    logic signed [SMP_W-1:0] lo;
    logic signed [SMP_W-1:0] soft_lo;
    logic signed [SMP_W-1:0] hi;

    in_range = (num <= LAST_CHECK);
    is_rail  = (num >= FIRST_SOFT) && (num <= LAST_SOFT);
    disabled = (32'(num) < CHECK_SLOTS) && disable_mask[num];
    rail     = is_rail ? RAIL_W'(num - FIRST_SOFT) : '0;
    cur      = cnt[rail];
    nval     = '0;
    upd      = 1'b0;
    kind     = KIND_NONE;

    // soft window of the selected rail
    case (rail)
      2'd0:    begin lo = R2_LO; soft_lo = R2_SOFT; hi = R2_HI; end
      2'd1:    begin lo = R3_LO; soft_lo = R3_SOFT; hi = R3_HI; end
      default: begin lo = R4_LO; soft_lo = R4_SOFT; hi = R4_HI; end
    endcase

    if (in_range && !disabled) begin
      case (num)
        5'd0: kind = (smp < R0_LO || smp > R0_HI) ? KIND_HARD : KIND_NONE;
        5'd1: kind = (smp < R1_LO || smp > R1_HI) ? KIND_HARD : KIND_NONE;
        5'd2, 5'd3, 5'd4: begin
          if (smp < lo || smp > hi) begin
            kind = KIND_HARD;
          end else if (smp < soft_lo) begin
            if (cur >= repeat_limit) begin
              kind = KIND_SOFT;
            end else begin
              upd  = 1'b1;
              nval = cur + 7'd1;
            end
          end else begin
            upd  = 1'b1;
            nval = '0;
          end
        end
        5'd5: kind = (smp < R5_LO || smp > R5_HI) ? KIND_HARD : KIND_NONE;
        5'd6, 5'd7, 5'd8:
          kind = (smp > TEMP_LOW) ? KIND_HARD : KIND_NONE;
        5'd12, 5'd18:
          kind = (smp > TEMP_HIGH) ? KIND_HARD : KIND_NONE;
        5'd15, 5'd21:
          kind = KIND_NONE;       // empty slots
        default:
          kind = (smp > TEMP_MID) ? KIND_HARD : KIND_NONE;
      endcase
    end

    // result and counter request
    ctl.rail    = rail;
    ctl.val     = nval;
    res.kind    = kind;
    res.fault   = (kind != KIND_NONE);
    if (kind != KIND_NONE) begin
      ctl.upd     = 1'b0;
      ctl.clr_all = 1'b1;
      res.next    = '0;
      res.low     = '0;
    end else begin
      ctl.upd     = upd;
      ctl.clr_all = 1'b0;
      res.next    = (!in_range || num == LAST_CHECK) ? '0 : num + 5'd1;
      res.low     = (is_rail && in_range) ? (upd ? nval : cur) : '0;
    end
  end

endmodule

[hdl/rtsm_counters.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtsm_counters: soft-low counter bank
// One consecutive-low counter per soft rail; a fault clears all of them.
// ----------------------------------------------------------------------------
module rtsm_counters (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  rtsm_pkg::cnt_ctl_t ctl,
  output rtsm_pkg::cnt_vec_t cnt
);
  import rtsm_pkg::*;

  cnt_vec_t cnt_r;
  cnt_vec_t cnt_nxt;

  // next counter values
  always_comb begin
    cnt_nxt = cnt_r;
    if (en) begin
      if (ctl.clr_all) begin
        cnt_nxt = '0;
      end else if (ctl.upd) begin
        cnt_nxt[ctl.rail] = ctl.val;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  assign cnt = cnt_r;

endmodule

[hdl/rail_and_temperature_safety_monitor.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rail_and_temperature_safety_monitor: telemetry limit checker
// Checks each telemetry sample against its fixed limits and reports faults.
// ----------------------------------------------------------------------------
// One sample beat is taken per clock while in_stall is low. A beat is held in
// an input register while its limits are checked, then lands in the result
// register as its soft-low counter is updated; one beat per cycle is sustained
// as long as results are taken. A stalled result register still lets one
// more beat into the input register; once both hold a beat, the input side
// is stalled in the same cycle as the result. The configuration port is
// always ready; write it only while the block is idle.
// ----------------------------------------------------------------------------
module rail_and_temperature_safety_monitor (
  input  logic                              clk,
  input  logic                              rst_n,
  // sample channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [rtsm_pkg::NUM_W-1:0]        in_check_number,
  input  logic signed [rtsm_pkg::SMP_W-1:0] in_sample,
  // result channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_fault,
  output logic [rtsm_pkg::KIND_W-1:0]       out_fault_kind,
  output logic [rtsm_pkg::NUM_W-1:0]        out_next_check,
  output logic [rtsm_pkg::CNT_W-1:0]        out_low_count,
  // configuration write channel
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [rtsm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rtsm_pkg::MASK_W-1:0]       cfg_data
);
  import rtsm_pkg::*;

  logic [MASK_W-1:0]       disable_mask_r;
  logic [CNT_W-1:0]        repeat_limit_r;
  logic                    s1_valid_r;
  logic                    s1_valid_nxt;
  logic [NUM_W-1:0]        s1_num_r;
  logic signed [SMP_W-1:0] s1_smp_r;
  logic                    out_valid_r;
  logic                    out_valid_nxt;
  res_t                    out_res_r;
  res_t                    res;
  cnt_ctl_t                ctl;
  cnt_vec_t                cnt;
  logic                    out_free;
  logic                    s1_adv;
  logic                    in_acc;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      disable_mask_r <= DISABLE_MASK_RST;
      repeat_limit_r <= REPEAT_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_DISABLE_MASK) begin
        disable_mask_r <= cfg_data;
      end
      if (cfg_index == CFG_REPEAT_LIMIT) begin
        repeat_limit_r <= cfg_data[CNT_W-1:0];
      end
    end
  end

  // pipeline flow
  assign out_free      = !out_valid_r || !out_stall;
  assign s1_adv        = s1_valid_r && out_free;
  assign in_stall      = s1_valid_r && !out_free;
  assign in_acc        = in_valid && !in_stall;
  assign s1_valid_nxt  = in_acc || (s1_valid_r && !s1_adv);
  assign out_valid_nxt = s1_adv || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_num_r <= in_check_number;
      s1_smp_r <= in_sample;
    end
  end

  rtsm_eval u_eval (
    .num          (s1_num_r),
    .smp          (s1_smp_r),
    .disable_mask (disable_mask_r),
    .repeat_limit (repeat_limit_r),
    .cnt          (cnt),
    .res          (res),
    .ctl          (ctl)
  );

  rtsm_counters u_counters (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (s1_adv),
    .ctl   (ctl),
    .cnt   (cnt)
  );

  // result register
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_res_r <= res;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_fault      = out_res_r.fault;
  assign out_fault_kind = out_res_r.kind;
  assign out_next_check = out_res_r.next;
  assign out_low_count  = out_res_r.low;

  // checks
  a_fault_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_fault |-> out_next_check == '0 && out_low_count == '0)
    else $error("fault result does not restart the scan");

  a_fault_matches_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_fault == (out_fault_kind != KIND_NONE))
    else $error("fault flag and kind disagree");

  a_fault_clears_counters: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && res.fault |=> cnt == '0)
    else $error("counters not cleared after a fault");

  a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r && out_valid_r)
    else $error("input stalled with room in the pipeline");

  a_result_follows_item: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(s1_valid_r))
    else $error("result appeared without an item in flight");

endmodule
